// ===== design/tpp_pkg.sv =====
package tpp_pkg;

    localparam int CHAR_W       = 8;
    localparam int COL_W        = 16;
    localparam int TAB_STOP_DEF = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = 3;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

    localparam logic [COL_W-1:0] COL_MAX = 16'hFFFF;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_POST_ENABLE       = 3'd0,
        REG_NL_ADDS_CR        = 3'd1,
        REG_NL_RETURNS_COLUMN = 3'd2,
        REG_DROP_CR_AT_START  = 3'd3,
        REG_CR_TO_NL          = 3'd4,
        REG_EXPAND_TABS       = 3'd5,
        REG_UPPER_CASE_OUT    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic post_enable;
        logic nl_adds_cr;
        logic nl_returns_column;
        logic drop_cr_at_start;
        logic cr_to_nl;
        logic expand_tabs;
        logic upper_case_out;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        post_enable:       1'b1,
        nl_adds_cr:        1'b1,
        nl_returns_column: 1'b0,
        drop_cr_at_start:  1'b0,
        cr_to_nl:          1'b0,
        expand_tabs:       1'b1,
        upper_case_out:    1'b0
    };

endpackage

// ===== design/tpp_in_if.sv =====
interface tpp_in_if import tpp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

// ===== design/tpp_out_if.sv =====
interface tpp_out_if import tpp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              last_of_run;

    modport source (output valid, output char_out, output last_of_run, input ready);
    modport sink (input valid, input char_out, input last_of_run, output ready);
endinterface

// ===== design/tpp_cfg.sv =====
module tpp_cfg import tpp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     rd_bit;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_POST_ENABLE:       n_cfg.post_enable       = pwdata[0];
                REG_NL_ADDS_CR:        n_cfg.nl_adds_cr        = pwdata[0];
                REG_NL_RETURNS_COLUMN: n_cfg.nl_returns_column = pwdata[0];
                REG_DROP_CR_AT_START:  n_cfg.drop_cr_at_start  = pwdata[0];
                REG_CR_TO_NL:          n_cfg.cr_to_nl          = pwdata[0];
                REG_EXPAND_TABS:       n_cfg.expand_tabs       = pwdata[0];
                REG_UPPER_CASE_OUT:    n_cfg.upper_case_out    = pwdata[0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_POST_ENABLE:       rd_bit = r_cfg.post_enable;
            REG_NL_ADDS_CR:        rd_bit = r_cfg.nl_adds_cr;
            REG_NL_RETURNS_COLUMN: rd_bit = r_cfg.nl_returns_column;
            REG_DROP_CR_AT_START:  rd_bit = r_cfg.drop_cr_at_start;
            REG_CR_TO_NL:          rd_bit = r_cfg.cr_to_nl;
            REG_EXPAND_TABS:       rd_bit = r_cfg.expand_tabs;
            REG_UPPER_CASE_OUT:    rd_bit = r_cfg.upper_case_out;
            default:               rd_bit = 1'b0;
        endcase
        prdata = {{(APB_DATA_W-1){1'b0}}, rd_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/tpp_front.sv =====
module tpp_front import tpp_pkg::*; #(
    parameter int TAB_STOP = TAB_STOP_DEF,
    parameter int CNT_W    = $clog2(TAB_STOP + 1),
    parameter int CMD_W    = 1 + CNT_W + CHAR_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    tpp_in_if.sink           i_req,
    input  logic             i_q_full,
    output logic             o_push,
    output logic [CMD_W-1:0] o_cmd
);

    localparam int PH_W = $clog2(TAB_STOP);
    localparam logic [PH_W-1:0] PhaseTop = PH_W'(TAB_STOP - 1);
    localparam logic [PH_W-1:0] PhaseMax = PH_W'(32'hFFFF % TAB_STOP);

    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [PH_W-1:0]   r_phase;
    logic [PH_W-1:0]   n_phase;
    logic              accept;
    logic              keep;
    logic              pre_cr;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  tab_n;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] c_in;
    logic [COL_W:0]    sum;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && !i_q_full;
    assign c_in        = i_req.char_in;
    assign tab_n       = CNT_W'(TAB_STOP) - CNT_W'(r_phase);
    assign o_push      = accept && keep;
    assign o_cmd       = {pre_cr, cnt, ch};

    always_comb begin
        n_col   = r_col;
        n_phase = r_phase;
        keep    = 1'b1;
        pre_cr  = 1'b0;
        cnt     = CNT_W'(1);
        ch      = c_in;
        sum     = {1'b0, r_col} + (COL_W+1)'(1);
        if (i_cfg.post_enable) begin
            case (c_in)
                CH_NL: begin
                    if (i_cfg.nl_returns_column || i_cfg.nl_adds_cr) begin
                        n_col   = '0;
                        n_phase = '0;
                    end
                    pre_cr = i_cfg.nl_adds_cr;
                end
                CH_CR: begin
                    if (i_cfg.drop_cr_at_start && r_col == '0) begin
                        keep = 1'b0;
                    end else if (i_cfg.cr_to_nl) begin
                        ch = CH_NL;
                        if (i_cfg.nl_returns_column) begin
                            n_col   = '0;
                            n_phase = '0;
                        end
                    end else begin
                        n_col   = '0;
                        n_phase = '0;
                    end
                end
                CH_TAB: begin
                    sum = {1'b0, r_col} + (COL_W+1)'(tab_n);
                    if (sum[COL_W]) begin
                        n_col   = COL_MAX;
                        n_phase = PhaseMax;
                    end else begin
                        n_col   = sum[COL_W-1:0];
                        n_phase = '0;
                    end
                    if (i_cfg.expand_tabs) begin
                        ch  = CH_SPACE;
                        cnt = tab_n;
                    end
                end
                CH_BS: begin
                    if (r_col != '0) begin
                        n_col   = r_col - COL_W'(1);
                        n_phase = (r_phase == '0) ? PhaseTop : r_phase - PH_W'(1);
                    end
                end
                default: begin
                    if (i_cfg.upper_case_out && c_in >= CH_LOW_A && c_in <= CH_LOW_Z) begin
                        ch = c_in - CASE_OFS;
                    end
                    if (!(c_in < CH_SPACE || c_in == CH_DEL)) begin
                        if (sum[COL_W]) begin
                            n_col   = COL_MAX;
                            n_phase = PhaseMax;
                        end else begin
                            n_col   = sum[COL_W-1:0];
                            n_phase = (r_phase == PhaseTop) ? '0 : r_phase + PH_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_phase <= '0;
        end else if (accept) begin
            r_col   <= n_col;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== design/tpp_queue.sv =====
module tpp_queue import tpp_pkg::*; #(
    parameter int WIDTH = CHAR_W,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== design/tpp_back.sv =====
module tpp_back import tpp_pkg::*; #(
    parameter int TAB_STOP = TAB_STOP_DEF,
    parameter int CNT_W    = $clog2(TAB_STOP + 1),
    parameter int CMD_W    = 1 + CNT_W + CHAR_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_pop,
    tpp_out_if.source        o_res
);

    logic              r_busy;
    logic              n_busy;
    logic              r_cr;
    logic [CNT_W-1:0]  r_rem;
    logic [CHAR_W-1:0] r_ch;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [CHAR_W-1:0] r_out_ch;
    logic              r_out_last;
    logic              src_cr;
    logic [CNT_W-1:0]  src_rem;
    logic [CHAR_W-1:0] src_ch;
    logic              load;

    assign o_res.valid       = r_out_valid;
    assign o_res.char_out    = r_out_ch;
    assign o_res.last_of_run = r_out_last;

    always_comb begin
        src_cr  = r_busy ? r_cr  : i_cmd[CMD_W-1];
        src_rem = r_busy ? r_rem : i_cmd[CHAR_W +: CNT_W];
        src_ch  = r_busy ? r_ch  : i_cmd[CHAR_W-1:0];
        load    = (r_busy || i_q_valid) && (!r_out_valid || o_res.ready);
        o_pop   = load && !r_busy;
        n_busy  = load ? (src_cr || src_rem != CNT_W'(1)) : r_busy;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ch       <= src_ch;
            r_cr       <= 1'b0;
            r_rem      <= src_cr ? src_rem : src_rem - CNT_W'(1);
            r_out_ch   <= src_cr ? CH_CR : src_ch;
            r_out_last <= !src_cr && (src_rem == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/tty_output_postprocessor_core.sv =====
// Terminal output post-processor. Bytes arrive on the request input one per cycle and
// leave on the result output, each result carrying last_of_run on the final byte that
// its request caused. A front stage keeps the printhead column and classifies each byte
// into a command (a byte with a repeat count and an optional leading carriage return);
// a two-entry queue carries commands to a back stage that sends one line byte per cycle
// through a registered output while that output is ready. Ordinary bytes therefore flow at one
// request per cycle via the queue and the output register; a request that yields several
// bytes (an expanded tab, a newline with added carriage return) holds the back stage until
// its last byte is sent, and requests stall once the queue is full. Configuration registers
// are to be written through the APB port only while no request is in flight (not enforced).
module tty_output_postprocessor_core import tpp_pkg::*; #(
    parameter int TAB_STOP = TAB_STOP_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tpp_in_if.sink                i_req,
    tpp_out_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(TAB_STOP + 1);
    localparam int CMD_W = 1 + CNT_W + CHAR_W;

    t_cfg             cfg;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    logic [CMD_W-1:0] cmd_in;
    logic [CMD_W-1:0] cmd_out;

    tpp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tpp_front #(
        .TAB_STOP (TAB_STOP),
        .CNT_W    (CNT_W),
        .CMD_W    (CMD_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (cmd_in)
    );

    tpp_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (cmd_out)
    );

    tpp_back #(
        .TAB_STOP (TAB_STOP),
        .CNT_W    (CNT_W),
        .CMD_W    (CMD_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (cmd_out),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule
